/* rtl/core/keyed_exclusion_set_unit_assert.svh */
// ----------------------------------------------------------------------------
// keyed exclusion set assertion macros
// concurrent checks clocked on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef KEYED_EXCLUSION_SET_UNIT_ASSERT_SVH
`define KEYED_EXCLUSION_SET_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define KES_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KES_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/kes_pkg.sv */
// ----------------------------------------------------------------------------
// kes_pkg
// shared constants, command and status codes and sequencer states
// ----------------------------------------------------------------------------
`default_nettype none

package kes_pkg;

   localparam int unsigned ENTRIES_DEFAULT   = 32;
   localparam int unsigned KEY_BYTES_DEFAULT = 64;

   localparam logic [1:0] CMD_MATCH  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ERROR     = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/keyed_exclusion_set_unit.sv */
// ----------------------------------------------------------------------------
// keyed_exclusion_set_unit
// content addressable set of zero-terminated keys held in one wide ram row each
// ----------------------------------------------------------------------------
// usage:
//   req channel carries a key as 64-bit beats (first byte in bits 7:0); the
//   beat with req_last_word set also carries the command (match, add, remove).
//   a non-last beat is taken and gives no result.
//   the last beat starts the sequencer: the stored keys are compared one ram
//   row per cycle, an add writes one row, a remove copies the rows above the
//   hit down one per cycle. one rsp beat (status, matched, entry_count) follows.
//   the result waits on the scan of the entry ram: up to the hit row, or all
//   stored_count rows when no key matches; an empty set or an unterminated
//   key skips the scan, and a remove adds the pack down of the rows above.
//   req_ready is low while a command runs. a finished result waits in the
//   output register; the next key's beats are taken while it waits, and only
//   a following command stalls until rsp_ready takes the earlier one.
//   reset empties the set and the key buffer at once; ram contents need no
//   clearing since only rows below the entry count are read.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_exclusion_set_unit #(
   parameter int unsigned ENTRIES   = kes_pkg::ENTRIES_DEFAULT,
   parameter int unsigned KEY_BYTES = kes_pkg::KEY_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [63:0] req_key_word,
   input  wire logic        req_last_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_matched,
   output logic [5:0]       rsp_entry_count
);

   localparam int unsigned KEY_WORDS = (KEY_BYTES + 7) / 8;
   localparam int unsigned KEY_BITS  = KEY_BYTES * 8;
   localparam int unsigned CW        = $clog2(ENTRIES + 1);
   localparam int unsigned AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned PW        = $clog2(KEY_WORDS + 1);
   localparam int unsigned LW        = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;

   kes_pkg::state_type state_ff, state_in;

   logic [63:0]   kbuf_ff [KEY_WORDS];
   logic          kbuf_we;
   logic [63:0]   nword;
   logic          nseen;
   logic [PW-1:0] word_pos_ff, word_pos_in;
   logic          zero_seen_ff, zero_seen_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [CW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [CW-1:0] hit_idx_ff, hit_idx_in;
   logic          pend_ff, pend_in;
   logic [1:0]    cmd_ff, cmd_in;
   logic          term_ff, term_in;
   logic          matched_ff, matched_in;
   logic [1:0]    status_ff, status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic          rsp_matched_ff, rsp_matched_in;
   logic [5:0]    rsp_count_ff, rsp_count_in;

   logic [KEY_WORDS*64-1:0] lanes;
   logic [KEY_BITS-1:0]     key_vec;
   logic                    key_hit;
   logic                    cmp_last;
   logic [CW-1:0]           shift_dst;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [KEY_BITS-1:0] ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [KEY_BITS-1:0] ram_rdata;

   kes_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // normalize the incoming beat: bytes after the first zero and past the key end clear
   always_comb begin
      logic [7:0] byte_v;
      logic       seen;
      int         base;
      seen  = zero_seen_ff;
      base  = int'(word_pos_ff) * 8;
      nword = '0;
      for (int b = 0; b < 8; b++) begin
         byte_v = req_key_word[8*b +: 8];
         if ((base + b) < int'(KEY_BYTES)) begin
            nword[8*b +: 8] = seen ? 8'h00 : byte_v;
            if (byte_v == 8'h00) begin
               seen = 1'b1;
            end
         end
      end
      nseen = seen;
   end

   // lanes never written for this key read as zero
   always_comb begin
      for (int w = 0; w < int'(KEY_WORDS); w++) begin
         lanes[w*64 +: 64] = (w < int'(word_pos_ff)) ? kbuf_ff[w] : 64'h0;
      end
   end

   assign key_vec   = lanes[KEY_BITS-1:0];
   assign key_hit   = (ram_rdata == key_vec);
   assign cmp_last  = ((cmp_idx_ff + CW'(1)) == count_ff);
   assign shift_dst = cmp_idx_ff - CW'(1);

   always_comb begin
      state_in       = state_ff;
      word_pos_in    = word_pos_ff;
      zero_seen_in   = zero_seen_ff;
      count_in       = count_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_idx_in     = cmp_idx_ff;
      hit_idx_in     = hit_idx_ff;
      pend_in        = pend_ff;
      cmd_in         = cmd_ff;
      term_in        = term_ff;
      matched_in     = matched_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_count_in   = rsp_count_ff;
      req_ready      = 1'b0;
      kbuf_we        = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = count_ff[AW-1:0];
      ram_wdata      = key_vec;
      ram_re         = 1'b0;
      ram_raddr      = scan_idx_ff[AW-1:0];

      case (state_ff)
         kes_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (word_pos_ff < PW'(KEY_WORDS)) begin
                  kbuf_we      = 1'b1;
                  zero_seen_in = nseen;
                  word_pos_in  = word_pos_ff + PW'(1);
               end
               if (req_last_word) begin
                  cmd_in      = req_command;
                  // bytes never delivered are zero and end the key
                  term_in     = zero_seen_in
                                || ((int'(word_pos_in) * 8) < int'(KEY_BYTES));
                  matched_in  = 1'b0;
                  scan_idx_in = '0;
                  pend_in     = 1'b0;
                  if (term_in && (count_ff != '0)) begin
                     state_in = kes_pkg::ST_SCAN;
                  end else begin
                     state_in = kes_pkg::ST_EXEC;
                  end
               end
            end
         end

         kes_pkg::ST_SCAN: begin
            // read row scan_idx while comparing the row read last cycle
            if (pend_ff && key_hit) begin
               matched_in = 1'b1;
               hit_idx_in = cmp_idx_ff;
               pend_in    = 1'b0;
               state_in   = kes_pkg::ST_EXEC;
            end else if (pend_ff && cmp_last) begin
               pend_in  = 1'b0;
               state_in = kes_pkg::ST_EXEC;
            end else if (scan_idx_ff < count_ff) begin
               ram_re      = 1'b1;
               pend_in     = 1'b1;
               cmp_idx_in  = scan_idx_ff;
               scan_idx_in = scan_idx_ff + CW'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = kes_pkg::ST_EXEC;
            end
         end

         kes_pkg::ST_EXEC: begin
            status_in = kes_pkg::STATUS_OK;
            state_in  = kes_pkg::ST_DONE;
            case (cmd_ff)
               kes_pkg::CMD_ADD: begin
                  if (!term_ff) begin
                     status_in = kes_pkg::STATUS_ERROR;
                  end else if (!matched_ff) begin
                     if (count_ff >= CW'(ENTRIES)) begin
                        status_in = kes_pkg::STATUS_ERROR;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
               end
               kes_pkg::CMD_REMOVE: begin
                  if (!matched_ff) begin
                     status_in = kes_pkg::STATUS_NOT_FOUND;
                  end else begin
                     scan_idx_in = hit_idx_ff + CW'(1);
                     pend_in     = 1'b0;
                     state_in    = kes_pkg::ST_SHIFT;
                  end
               end
               default: begin
                  status_in = kes_pkg::STATUS_OK;
               end
            endcase
         end

         kes_pkg::ST_SHIFT: begin
            // pack down: row read last cycle goes one row lower
            ram_we    = pend_ff;
            ram_waddr = shift_dst[AW-1:0];
            ram_wdata = ram_rdata;
            if (scan_idx_ff < count_ff) begin
               ram_re      = 1'b1;
               pend_in     = 1'b1;
               cmp_idx_in  = scan_idx_ff;
               scan_idx_in = scan_idx_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = kes_pkg::ST_DONE;
               end
            end
         end

         kes_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_matched_in = matched_ff;
               rsp_count_in   = 6'(count_ff);
               word_pos_in    = '0;
               zero_seen_in   = 1'b0;
               state_in       = kes_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kes_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kes_pkg::ST_IDLE;
         word_pos_ff  <= '0;
         zero_seen_ff <= 1'b0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_pos_ff  <= word_pos_in;
         zero_seen_ff <= zero_seen_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff    <= scan_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      hit_idx_ff     <= hit_idx_in;
      cmd_ff         <= cmd_in;
      term_ff        <= term_in;
      matched_ff     <= matched_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_count_ff   <= rsp_count_in;
      if (kbuf_we) begin
         kbuf_ff[word_pos_ff[LW-1:0]] <= nword;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_entry_count = rsp_count_ff;

`include "keyed_exclusion_set_unit_assert.svh"

   `KES_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(ENTRIES), "entry count above capacity")
   `KES_ASSERT_NOW(a_ram_we_state, ram_we, (state_ff == kes_pkg::ST_EXEC) || (state_ff == kes_pkg::ST_SHIFT), "entry ram written outside exec or shift")
   `KES_ASSERT_NOW(a_shift_dst, ram_we && (state_ff == kes_pkg::ST_SHIFT), (cmp_idx_ff != '0) && (cmp_idx_ff < count_ff), "pack down writes outside stored rows")
   `KES_ASSERT_NOW(a_read_bound, ram_re, scan_idx_ff < count_ff, "entry ram read beyond stored rows")
   `KES_ASSERT_NEXT(a_done_load, (state_ff == kes_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == kes_pkg::ST_IDLE) && (word_pos_ff == '0), "finished command did not post a result")

endmodule

`default_nettype wire

/* rtl/core/kes_ram.sv */
// ----------------------------------------------------------------------------
// kes_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module kes_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                                     clock,
   input  wire logic                                     we,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                         wdata,
   input  wire logic                                     re,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic      [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: keyed exclusion set unit testbench
// keys are sent as 64-bit beats with match, add and remove commands and an unused code; a
// scoreboard keeps its own copy of the key buffer and the stored set and
// checks every result beat in order. both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned KEY_WORDS = kes_pkg::KEY_BYTES_DEFAULT / 8;
   localparam int unsigned KEY_BITS  = kes_pkg::KEY_BYTES_DEFAULT * 8;
   localparam logic [1:0]  CMD_UNUSED = 2'd3;

   localparam int POOL_SIZE    = 48;
   localparam int TARGET_BEATS = 750;
   localparam int ROUND_LENGTH = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      logic [1:0] status;
      logic       matched;
      logic [5:0] entry_count;
   } set_response_type;

   class key_set_scoreboard;
      logic [63:0]         key_words [KEY_WORDS];
      int unsigned         word_count;
      logic [KEY_BITS-1:0] stored_keys [kes_pkg::ENTRIES_DEFAULT];
      int unsigned         stored_count;
      set_response_type    pending_responses [$];
      int unsigned         failures;

      function new();
         clear_key();
         stored_count = 0;
         failures = 0;
      endfunction

      function void clear_key();
         foreach (key_words[w]) key_words[w] = '0;
         word_count = 0;
      endfunction

      function int unsigned pending_count();
         return pending_responses.size();
      endfunction

      // absorbs one accepted beat; a last beat runs the command on the set
      function void note_beat(logic [1:0] command, logic [63:0] key_word, logic last_word);
         logic [KEY_BITS-1:0] key;
         bit                  terminated;
         bit                  found;
         int unsigned         hit;
         set_response_type    rsp;
         if (word_count < KEY_WORDS) begin
            key_words[word_count] = key_word;
            word_count++;
         end
         if (!last_word) return;
         for (int w = 0; w < KEY_WORDS; w++) key[w*64 +: 64] = key_words[w];
         // bytes after the first zero do not belong to the key
         terminated = 0;
         for (int b = 0; b < kes_pkg::KEY_BYTES_DEFAULT; b++) begin
            if (terminated) key[b*8 +: 8] = 8'h00;
            else if (key[b*8 +: 8] == 8'h00) terminated = 1;
         end
         found = 0;
         hit = stored_count;
         if (terminated) begin
            for (int unsigned i = 0; i < stored_count; i++) begin
               if (!found && stored_keys[i] == key) begin
                  found = 1;
                  hit = i;
               end
            end
         end
         rsp.status = kes_pkg::STATUS_OK;
         rsp.matched = found;
         case (command)
            kes_pkg::CMD_ADD: begin
               if (!terminated) rsp.status = kes_pkg::STATUS_ERROR;
               else if (!found) begin
                  if (stored_count >= kes_pkg::ENTRIES_DEFAULT) begin
                     rsp.status = kes_pkg::STATUS_ERROR;
                  end else begin
                     stored_keys[stored_count] = key;
                     stored_count++;
                  end
               end
            end
            kes_pkg::CMD_REMOVE: begin
               if (!found) rsp.status = kes_pkg::STATUS_NOT_FOUND;
               else begin
                  for (int unsigned i = hit; i + 1 < stored_count; i++)
                     stored_keys[i] = stored_keys[i + 1];
                  stored_count--;
               end
            end
            default: ;
         endcase
         rsp.entry_count = stored_count[5:0];
         pending_responses.push_back(rsp);
         clear_key();
      endfunction

      function void check_response(logic [1:0] status, logic matched, logic [5:0] entry_count);
         set_response_type want;
         if (pending_responses.size() == 0) begin
            $error("result beat with no command waiting: status %0d matched %0d entry_count %0d",
                   status, matched, entry_count);
            failures++;
            return;
         end
         want = pending_responses.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
         if (matched !== want.matched) begin
            $error("matched: expected %0d, actual %0d", want.matched, matched);
            failures++;
         end
         if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [63:0] req_key_word;
   logic        req_last_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic        rsp_matched;
   logic [5:0]  rsp_entry_count;

   key_set_scoreboard   sb;
   bit                  quiet_sides;
   bit                  hold_request;
   int unsigned         beats_sent;
   int unsigned         cycle_count;
   logic [KEY_BITS-1:0] pool_content [POOL_SIZE];
   int                  pool_len [POOL_SIZE];

   keyed_exclusion_set_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_key_word   (req_key_word),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_matched    (rsp_matched),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // every byte nonzero, so the key length alone places the terminator
   function automatic logic [KEY_BITS-1:0] random_content();
      logic [KEY_BITS-1:0] bytes;
      for (int b = 0; b < kes_pkg::KEY_BYTES_DEFAULT; b++) begin
         bytes[b*8 +: 8] = 8'($urandom_range(1, 255));
      end
      return bytes;
   endfunction

   task automatic send_beat(logic [1:0] cmd, logic [63:0] word, logic last);
      int unsigned gap;
      gap = quiet_sides ? 0 : $urandom_range(0, 17);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_key_word  <= word;
      req_last_word <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(cmd, word, last);
      beats_sent++;
   endtask

   // key of len nonzero bytes, then a zero, then random filler up to nwords beats
   task automatic send_key(logic [1:0] cmd, logic [KEY_BITS-1:0] content, int len, int nwords);
      logic [63:0] word;
      int          pos;
      for (int w = 0; w < nwords; w++) begin
         word = {$urandom, $urandom};
         for (int b = 0; b < 8; b++) begin
            pos = w * 8 + b;
            if (pos < len && pos < kes_pkg::KEY_BYTES_DEFAULT) begin
               word[b*8 +: 8] = content[pos*8 +: 8];
            end else if (pos == len) begin
               word[b*8 +: 8] = 8'h00;
            end
         end
         if (w == nwords - 1) send_beat(cmd, word, 1'b1);
         else send_beat(2'($urandom_range(0, 3)), word, 1'b0);
      end
   endtask

   task automatic random_command(int add_weight, int remove_weight);
      int                  pick;
      int                  len;
      int                  needed;
      int                  nwords;
      logic [1:0]          cmd;
      logic [KEY_BITS-1:0] content;
      pick = $urandom_range(0, 99);
      if (pick < add_weight) cmd = kes_pkg::CMD_ADD;
      else if (pick < add_weight + remove_weight) cmd = kes_pkg::CMD_REMOVE;
      else if (pick < 95) cmd = kes_pkg::CMD_MATCH;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 9) == 0) begin
         content = random_content();
         len = $urandom_range(0, 70);
      end else begin
         pick = $urandom_range(0, POOL_SIZE - 1);
         content = pool_content[pick];
         len = pool_len[pick];
      end
      needed = (len >= kes_pkg::KEY_BYTES_DEFAULT) ? KEY_WORDS : len / 8 + 1;
      pick = $urandom_range(0, 9);
      // short deliveries cut the key, long ones add beats after its end
      if (pick == 0 && needed > 1) nwords = $urandom_range(1, needed - 1);
      else if (pick == 1) nwords = needed + $urandom_range(1, 3);
      else nwords = needed;
      send_key(cmd, content, len, nwords);
   endtask

   // the sender goes quiet first so no beat is offered while results drain
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned gap;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = quiet_sides ? 0 : $urandom_range(0, 17);
         if (hold_request) begin
            gap = HOLD_CYCLES;
            hold_request = 0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_status, rsp_matched, rsp_entry_count);
      end
   end

   initial begin
      logic [KEY_BITS-1:0] zero_key;
      logic [KEY_BITS-1:0] ones_key;
      int                  round;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = kes_pkg::CMD_MATCH;
      req_key_word = '0;
      req_last_word = 1'b0;
      quiet_sides = 0;
      hold_request = 0;
      beats_sent = 0;
      cycle_count = 0;
      zero_key = '0;
      ones_key = '1;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_content[i] = random_content();
         pool_len[i] = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : $urandom_range(1, 63);
      end
      // near neighbours: same prefix, one byte longer
      pool_content[1] = pool_content[0];
      pool_len[1] = pool_len[0] + 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty key, empty set, duplicate add, unused code
      send_key(kes_pkg::CMD_MATCH, zero_key, 0, 1);
      send_key(kes_pkg::CMD_REMOVE, zero_key, 0, 1);
      send_key(kes_pkg::CMD_ADD, zero_key, 0, 1);
      send_key(kes_pkg::CMD_ADD, zero_key, 0, 2);
      send_key(kes_pkg::CMD_MATCH, zero_key, 0, 1);
      send_key(CMD_UNUSED, zero_key, 0, 1);
      // longest key that fits, then keys with no terminator
      send_key(kes_pkg::CMD_ADD, ones_key, 63, 8);
      send_key(kes_pkg::CMD_ADD, ones_key, 64, 8);
      send_key(kes_pkg::CMD_MATCH, ones_key, 64, 8);
      send_key(kes_pkg::CMD_REMOVE, ones_key, 64, 10);
      // beats past the buffer are dropped
      send_key(kes_pkg::CMD_ADD, ones_key, 63, 11);
      // missing beats read as zero
      send_key(kes_pkg::CMD_MATCH, ones_key, 62, 3);
      send_key(kes_pkg::CMD_REMOVE, zero_key, 0, 1);
      send_key(kes_pkg::CMD_MATCH, ones_key, 63, 8);
      send_key(kes_pkg::CMD_REMOVE, ones_key, 63, 8);
      send_key(kes_pkg::CMD_REMOVE, ones_key, 63, 8);

      // fill past capacity so adds hit the full set
      for (int i = 0; i < POOL_SIZE; i++)
         send_key(kes_pkg::CMD_ADD, pool_content[i], pool_len[i], pool_len[i] / 8 + 1);

      round = 0;
      while (beats_sent < TARGET_BEATS) begin
         quiet_sides = ($urandom_range(0, 3) == 0);
         if (round == 1) begin
            quiet_sides = 0;
            hold_request = 1;
         end
         if (round == 2) wait_for_results();
         for (int n = 0; n < ROUND_LENGTH; n++) begin
            case (round % 3)
               0: random_command(15, 65);
               1: random_command(35, 30);
               default: random_command(65, 15);
            endcase
         end
         round++;
      end
      quiet_sides = 0;

      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending_count() == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/kes_pkg.sv
rtl/core/kes_ram.sv
rtl/core/keyed_exclusion_set_unit.sv
verif/tb_top.sv
